// ===== rtl/itp_pkg.sv =====
// Shared types, constants and the control store of the track position block.
package itp_pkg;

  // Fixed field widths.
  localparam int unsigned LVL_W = 22;
  localparam int unsigned ERR_W = 23;
  localparam int unsigned POS_W = 32;
  localparam int unsigned THR_W = 20;
  localparam int unsigned UPC_W = 5;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_MEAS      = 2'd0;
  localparam logic [1:0] ACT_CAL_START = 2'd1;
  localparam logic [1:0] ACT_CAL_ACC   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOST = 2'd0;
  localparam logic [1:0] REG_CC   = 2'd1;
  localparam logic [1:0] REG_CS   = 2'd2;

  // Reset values of the thresholds.
  localparam logic [THR_W-1:0] LOST_RST = 20'd20;
  localparam logic [THR_W-1:0] CC_RST   = 20'd250;
  localparam logic [THR_W-1:0] CS_RST   = 20'd100;

  // Divide by 200: shift by 3, then multiply by ceil(2^34/25) and shift by 34.
  localparam logic signed [31:0] RECIP_25   = 32'sd687194768;
  // Divide by 3125 estimate: shift by 12, then multiply by floor(2^42/3125) and shift by 30.
  localparam logic signed [31:0] RECIP_3125 = 32'sd1407374883;
  localparam logic signed [31:0] DIV_3125   = 32'sd3125;
  localparam logic [13:0]        REM_3125   = 14'd3125;

  // Polynomial constants, written as e*(e-10)*e + 165770*e - 2060400.
  localparam logic signed [22:0] POLY_C1  = 23'sd10;
  localparam logic signed [35:0] POLY_C2  = 36'sd165770;
  localparam logic signed [50:0] POLY_C0  = 51'sd2060400;
  localparam logic signed [22:0] CUBE_LIM = 23'sd100000;

  localparam logic [24:0] LVL_POS_LIM = 25'd2097151;
  localparam logic [24:0] LVL_NEG_LIM = 25'd2097152;
  localparam logic signed [LVL_W-1:0] LVL_MAX = 22'sd2097151;
  localparam logic signed [LVL_W-1:0] LVL_MIN = -22'sd2097152;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic [31:0] POS_NEG_LIM = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAL_LD,
    OP_CAL_ACC,
    OP_ERR,
    OP_U,
    OP_P,
    OP_DIV,
    OP_Q,
    OP_R,
    OP_CORR,
    OP_POS,
    OP_SATE,
    OP_SATP,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    CH_NONE,
    CH_L,
    CH_C,
    CH_R
  } ch_e;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_HOLD,
    JC_EBIG,
    JC_PBIG,
    JC_RGE,
    JC_OBUSY
  } jc_e;

  typedef struct packed {
    op_e              op;
    ch_e              ld;
    ch_e              wr;
    jc_e              jc;
    logic [UPC_W-1:0] tgt;
    logic             fin;
  } ucw_t;

  typedef struct packed {
    logic cap;
    ucw_t uw;
  } ctrl_t;

  typedef struct packed {
    logic hold;
    logic e_big;
    logic p_big;
    logic r_ge;
    logic o_busy;
  } stat_t;

  // Control store addresses.
  localparam logic [UPC_W-1:0] U_LDL    = 5'd0;
  localparam logic [UPC_W-1:0] U_LDC    = 5'd1;
  localparam logic [UPC_W-1:0] U_LDR    = 5'd2;
  localparam logic [UPC_W-1:0] U_WRC    = 5'd3;
  localparam logic [UPC_W-1:0] U_WRR    = 5'd4;
  localparam logic [UPC_W-1:0] U_ERR    = 5'd5;
  localparam logic [UPC_W-1:0] U_W0     = 5'd6;
  localparam logic [UPC_W-1:0] U_U      = 5'd7;
  localparam logic [UPC_W-1:0] U_W1     = 5'd8;
  localparam logic [UPC_W-1:0] U_P      = 5'd9;
  localparam logic [UPC_W-1:0] U_DIV    = 5'd10;
  localparam logic [UPC_W-1:0] U_W2     = 5'd11;
  localparam logic [UPC_W-1:0] U_Q      = 5'd12;
  localparam logic [UPC_W-1:0] U_W3     = 5'd13;
  localparam logic [UPC_W-1:0] U_R      = 5'd14;
  localparam logic [UPC_W-1:0] U_CORR   = 5'd15;
  localparam logic [UPC_W-1:0] U_POS    = 5'd16;
  localparam logic [UPC_W-1:0] U_SATE   = 5'd17;
  localparam logic [UPC_W-1:0] U_SATP   = 5'd18;
  localparam logic [UPC_W-1:0] U_EMIT   = 5'd19;
  localparam logic [UPC_W-1:0] U_CAL_LD = 5'd20;
  localparam logic [UPC_W-1:0] U_CAL_AC = 5'd21;

  function automatic ucw_t mk_uw(op_e op, ch_e ld, ch_e wr, jc_e jc,
                                 logic [UPC_W-1:0] tgt, logic fin);
    ucw_t w;
    w.op  = op;
    w.ld  = ld;
    w.wr  = wr;
    w.jc  = jc;
    w.tgt = tgt;
    w.fin = fin;
    return w;
  endfunction

  // The microprogram. A measure beat runs from U_LDL to U_EMIT; the flag check
  // branches straight to the end, the range checks to a saturating step before it.
  function automatic ucw_t ucode(logic [UPC_W-1:0] a);
    ucw_t w;
    case (a)
      U_LDL:    w = mk_uw(OP_NOP,     CH_L,    CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_LDC:    w = mk_uw(OP_NOP,     CH_C,    CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_LDR:    w = mk_uw(OP_NOP,     CH_R,    CH_L,    JC_NONE,   U_LDL,  1'b0);
      U_WRC:    w = mk_uw(OP_NOP,     CH_NONE, CH_C,    JC_NONE,   U_LDL,  1'b0);
      U_WRR:    w = mk_uw(OP_NOP,     CH_NONE, CH_R,    JC_NONE,   U_LDL,  1'b0);
      U_ERR:    w = mk_uw(OP_ERR,     CH_NONE, CH_NONE, JC_HOLD,   U_EMIT, 1'b0);
      U_W0:     w = mk_uw(OP_NOP,     CH_NONE, CH_NONE, JC_EBIG,   U_SATE, 1'b0);
      U_U:      w = mk_uw(OP_U,       CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_W1:     w = mk_uw(OP_NOP,     CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_P:      w = mk_uw(OP_P,       CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_DIV:    w = mk_uw(OP_DIV,     CH_NONE, CH_NONE, JC_PBIG,   U_SATP, 1'b0);
      U_W2:     w = mk_uw(OP_NOP,     CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_Q:      w = mk_uw(OP_Q,       CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_W3:     w = mk_uw(OP_NOP,     CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_R:      w = mk_uw(OP_R,       CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_CORR:   w = mk_uw(OP_CORR,    CH_NONE, CH_NONE, JC_RGE,    U_CORR, 1'b0);
      U_POS:    w = mk_uw(OP_POS,     CH_NONE, CH_NONE, JC_ALWAYS, U_EMIT, 1'b0);
      U_SATE:   w = mk_uw(OP_SATE,    CH_NONE, CH_NONE, JC_ALWAYS, U_EMIT, 1'b0);
      U_SATP:   w = mk_uw(OP_SATP,    CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b0);
      U_EMIT:   w = mk_uw(OP_EMIT,    CH_NONE, CH_NONE, JC_OBUSY,  U_EMIT, 1'b1);
      U_CAL_LD: w = mk_uw(OP_CAL_LD,  CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b1);
      U_CAL_AC: w = mk_uw(OP_CAL_ACC, CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b1);
      default:  w = mk_uw(OP_NOP,     CH_NONE, CH_NONE, JC_NONE,   U_LDL,  1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/inductive_track_position.sv =====
// A measure beat yields its result at the emit step of the microprogram, which waits
// while the result register is stalled; the cubic path adds a quotient correction loop.
// Throughput: one beat at a time; the next beat is taken the cycle after the last step
// of the microprogram, which is paced by the one shared 36x32 multiplier.
// Reset: thresholds 20, 250 and 100, offsets and held position zero, sequencer idle;
// calibration beats give no result.
module inductive_track_position #(
  parameter int SAMPLE_BITS = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [itp_pkg::THR_W-1:0]         cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [SAMPLE_BITS-1:0]            left_sample_i,
  input  logic [SAMPLE_BITS-1:0]            centre_sample_i,
  input  logic [SAMPLE_BITS-1:0]            right_sample_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [itp_pkg::LVL_W-1:0]  left_level_o,
  output logic signed [itp_pkg::LVL_W-1:0]  right_level_o,
  output logic signed [itp_pkg::ERR_W-1:0]  side_error_o,
  output logic signed [itp_pkg::POS_W-1:0]  position_o,
  output logic                              lost_o,
  output logic                              crossing_o
);

  // The sequencer steps through a small control store. Each control word
  // picks a channel to load into the multiplier, a channel whose level is
  // written back, one datapath operation and an optional branch. The
  // datapath reports the branch conditions: flags set, error out of the
  // cubic range, product too large for a 32-bit result, remainder still at
  // or above the divisor, and the result register still waiting on its beat.
  itp_pkg::ctrl_t ctrl;
  itp_pkg::stat_t stat;

  itp_useq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Levels divide by 200 through a reciprocal multiply; the cubic is
  // evaluated as e*(e-10)*e + 165770*e - 2060400 in two multiplies, and the
  // division by 100000 is a shift by five, a reciprocal estimate of the
  // quotient by 3125 and a short correction loop on the remainder.
  itp_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .left_sample_i   (left_sample_i),
    .centre_sample_i (centre_sample_i),
    .right_sample_i  (right_sample_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .left_level_o    (left_level_o),
    .right_level_o   (right_level_o),
    .side_error_o    (side_error_o),
    .position_o      (position_o),
    .lost_o          (lost_o),
    .crossing_o      (crossing_o)
  );

endmodule

// ===== rtl/itp_useq.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
module itp_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  itp_pkg::stat_t      stat_i,
  output itp_pkg::ctrl_t      ctrl_o
);

  logic                       busy_q, busy_d;
  logic [itp_pkg::UPC_W-1:0]  upc_q, upc_d;
  itp_pkg::ucw_t              uw;
  logic                       take;
  logic                       accept;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  always_comb begin
    if (busy_q) begin
      uw = itp_pkg::ucode(upc_q);
    end else begin
      uw = itp_pkg::mk_uw(itp_pkg::OP_NOP, itp_pkg::CH_NONE, itp_pkg::CH_NONE,
                          itp_pkg::JC_NONE, itp_pkg::U_LDL, 1'b0);
    end
  end

  always_comb begin
    case (uw.jc)
      itp_pkg::JC_ALWAYS: take = 1'b1;
      itp_pkg::JC_HOLD:   take = stat_i.hold;
      itp_pkg::JC_EBIG:   take = stat_i.e_big;
      itp_pkg::JC_PBIG:   take = stat_i.p_big;
      itp_pkg::JC_RGE:    take = stat_i.r_ge;
      itp_pkg::JC_OBUSY:  take = stat_i.o_busy;
      default:            take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (busy_q) begin
      if (take) begin
        upc_d = uw.tgt;
      end else if (uw.fin) begin
        busy_d = 1'b0;
      end else begin
        upc_d = upc_q + 1'b1;
      end
    end else if (accept) begin
      case (action_i)
        itp_pkg::ACT_MEAS: begin
          busy_d = 1'b1;
          upc_d  = itp_pkg::U_LDL;
        end
        itp_pkg::ACT_CAL_START: begin
          busy_d = 1'b1;
          upc_d  = itp_pkg::U_CAL_LD;
        end
        itp_pkg::ACT_CAL_ACC: begin
          busy_d = 1'b1;
          upc_d  = itp_pkg::U_CAL_AC;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= itp_pkg::U_LDL;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign ctrl_o.cap = accept;
  assign ctrl_o.uw  = uw;

endmodule

// ===== rtl/itp_dpath.sv =====
// Datapath: offsets, thresholds, shared multiplier, levels, position and result register.
module itp_dpath #(
  parameter int SAMPLE_BITS = 28
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  itp_pkg::ctrl_t                       ctrl_i,
  output itp_pkg::stat_t                       stat_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [itp_pkg::THR_W-1:0]            cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]               left_sample_i,
  input  logic [SAMPLE_BITS-1:0]               centre_sample_i,
  input  logic [SAMPLE_BITS-1:0]               right_sample_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [itp_pkg::LVL_W-1:0]     left_level_o,
  output logic signed [itp_pkg::LVL_W-1:0]     right_level_o,
  output logic signed [itp_pkg::ERR_W-1:0]     side_error_o,
  output logic signed [itp_pkg::POS_W-1:0]     position_o,
  output logic                                 lost_o,
  output logic                                 crossing_o
);

  localparam int SB = SAMPLE_BITS;

  // Saturating level from a magnitude quotient and the sign of the difference.
  function automatic logic signed [21:0] sat_level(logic [24:0] q, logic neg);
    logic signed [21:0] r;
    if (neg) begin
      if (q > itp_pkg::LVL_NEG_LIM) r = itp_pkg::LVL_MIN;
      else                          r = $signed(22'd0 - 22'(q));
    end else begin
      if (q > itp_pkg::LVL_POS_LIM) r = itp_pkg::LVL_MAX;
      else                          r = $signed(22'(q));
    end
    return r;
  endfunction

  itp_pkg::ucw_t uw;
  assign uw = ctrl_i.uw;

  logic [SB-1:0] smp_l_q, smp_c_q, smp_r_q;
  logic [SB-1:0] off_l_q, off_c_q, off_r_q;
  logic [itp_pkg::THR_W-1:0] thr_lost_q, thr_cc_q, thr_cs_q;

  logic signed [35:0] ma_q, ma_d;
  logic signed [31:0] mb_q, mb_d;
  logic signed [67:0] prod_q;

  logic [2:0]         sgn_q;
  logic signed [21:0] lv_q, cv_q, rv_q;
  logic signed [22:0] err_q, err_c;
  logic               lost_q, cross_q, lost_c, cross_c;
  logic [44:0]        x_q;
  logic               psgn_q;
  logic [31:0]        q_q;
  logic [13:0]        r_q;
  logic signed [31:0] held_q;

  logic [SB-1:0]      ld_s, ld_o;
  logic signed [SB:0] diff;
  logic [SB-1:0]      mag;
  logic [24:0]        lq;
  logic               wneg;
  logic signed [21:0] lvl_c;
  logic signed [50:0] pv;
  logic [49:0]        pmag;
  logic [31:0]        qe;
  logic [44:0]        rfull;
  logic signed [31:0] pos_c;
  logic               emit;

  // Sample capture on an accepted input beat.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      smp_l_q <= left_sample_i;
      smp_c_q <= centre_sample_i;
      smp_r_q <= right_sample_i;
    end
  end

  // Offsets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_l_q <= '0;
      off_c_q <= '0;
      off_r_q <= '0;
    end else if (uw.op == itp_pkg::OP_CAL_LD) begin
      off_l_q <= smp_l_q;
      off_c_q <= smp_c_q;
      off_r_q <= smp_r_q;
    end else if (uw.op == itp_pkg::OP_CAL_ACC) begin
      off_l_q <= SB'(({1'b0, off_l_q} + {1'b0, smp_l_q}) >> 1);
      off_c_q <= SB'(({1'b0, off_c_q} + {1'b0, smp_c_q}) >> 1);
      off_r_q <= SB'(({1'b0, off_r_q} + {1'b0, smp_r_q}) >> 1);
    end
  end

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lost_q <= itp_pkg::LOST_RST;
      thr_cc_q   <= itp_pkg::CC_RST;
      thr_cs_q   <= itp_pkg::CS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        itp_pkg::REG_LOST: thr_lost_q <= cfg_data_i;
        itp_pkg::REG_CC:   thr_cc_q   <= cfg_data_i;
        itp_pkg::REG_CS:   thr_cs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Channel selected for the divide-by-200 operand load.
  always_comb begin
    case (uw.ld)
      itp_pkg::CH_C: begin
        ld_s = smp_c_q;
        ld_o = off_c_q;
      end
      itp_pkg::CH_R: begin
        ld_s = smp_r_q;
        ld_o = off_r_q;
      end
      default: begin
        ld_s = smp_l_q;
        ld_o = off_l_q;
      end
    endcase
    diff = $signed({1'b0, ld_s}) - $signed({1'b0, ld_o});
    mag  = diff[SB] ? SB'(-diff) : diff[SB-1:0];
  end

  assign err_c = 23'(rv_q) - 23'(lv_q);
  assign pv    = $signed(prod_q[50:0]) - itp_pkg::POLY_C0;
  assign pmag  = pv[50] ? 50'(-pv) : pv[49:0];
  assign qe    = prod_q[61:30];
  assign rfull = x_q - prod_q[44:0];

  // Multiplier operand selection.
  always_comb begin
    ma_d = ma_q;
    mb_d = mb_q;
    if (uw.ld != itp_pkg::CH_NONE) begin
      ma_d = $signed(36'(mag >> 3));
      mb_d = itp_pkg::RECIP_25;
    end
    case (uw.op)
      itp_pkg::OP_ERR: begin
        ma_d = 36'(err_c - itp_pkg::POLY_C1);
        mb_d = 32'(err_c);
      end
      itp_pkg::OP_U: begin
        ma_d = $signed(prod_q[35:0]) + itp_pkg::POLY_C2;
        mb_d = 32'(err_q);
      end
      itp_pkg::OP_DIV: begin
        ma_d = $signed(36'(x_q[42:12]));
        mb_d = itp_pkg::RECIP_3125;
      end
      itp_pkg::OP_Q: begin
        ma_d = $signed(36'(qe));
        mb_d = itp_pkg::DIV_3125;
      end
      default: ;
    endcase
  end

  // Shared multiplier with registered operands and product.
  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    prod_q <= ma_q * mb_q;
  end

  // Level write-back from the divide-by-200 product.
  always_comb begin
    lq = prod_q[58:34];
    case (uw.wr)
      itp_pkg::CH_C: wneg = sgn_q[1];
      itp_pkg::CH_R: wneg = sgn_q[2];
      default:       wneg = sgn_q[0];
    endcase
    lvl_c = sat_level(lq, wneg);
  end

  always_comb begin
    lost_c  = cv_q < $signed({2'b00, thr_lost_q});
    cross_c = (cv_q >= $signed({2'b00, thr_cc_q})) &&
              (lv_q > $signed({2'b00, thr_cs_q})) &&
              (rv_q > $signed({2'b00, thr_cs_q}));
  end

  always_ff @(posedge clk_i) begin
    case (uw.ld)
      itp_pkg::CH_L: sgn_q[0] <= diff[SB];
      itp_pkg::CH_C: sgn_q[1] <= diff[SB];
      itp_pkg::CH_R: sgn_q[2] <= diff[SB];
      default: ;
    endcase
    case (uw.wr)
      itp_pkg::CH_L: lv_q <= lvl_c;
      itp_pkg::CH_C: cv_q <= lvl_c;
      itp_pkg::CH_R: rv_q <= lvl_c;
      default: ;
    endcase
    case (uw.op)
      itp_pkg::OP_ERR: begin
        err_q   <= err_c;
        lost_q  <= lost_c;
        cross_q <= cross_c;
      end
      itp_pkg::OP_P: begin
        x_q    <= pmag[49:5];
        psgn_q <= pv[50];
      end
      itp_pkg::OP_Q: q_q <= qe;
      itp_pkg::OP_R: r_q <= rfull[13:0];
      itp_pkg::OP_CORR: begin
        if (r_q >= itp_pkg::REM_3125) begin
          r_q <= r_q - itp_pkg::REM_3125;
          q_q <= q_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  // Signed, saturated quotient.
  always_comb begin
    if (psgn_q) begin
      if (q_q > itp_pkg::POS_NEG_LIM) pos_c = itp_pkg::POS_MIN;
      else                            pos_c = $signed(32'd0 - q_q);
    end else begin
      if (q_q[31]) pos_c = itp_pkg::POS_MAX;
      else         pos_c = $signed(q_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      case (uw.op)
        itp_pkg::OP_POS:  held_q <= pos_c;
        itp_pkg::OP_SATE: held_q <= err_q[22] ? itp_pkg::POS_MIN : itp_pkg::POS_MAX;
        itp_pkg::OP_SATP: held_q <= psgn_q ? itp_pkg::POS_MIN : itp_pkg::POS_MAX;
        default: ;
      endcase
    end
  end

  // Result register.
  assign emit = (uw.op == itp_pkg::OP_EMIT) && !(out_valid_o && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      left_level_o  <= lv_q;
      right_level_o <= rv_q;
      side_error_o  <= err_q;
      position_o    <= held_q;
      lost_o        <= lost_q;
      crossing_o    <= cross_q;
    end
  end

  assign stat_o.hold   = lost_c || cross_c;
  assign stat_o.e_big  = (err_q > itp_pkg::CUBE_LIM) || (err_q < -itp_pkg::CUBE_LIM);
  assign stat_o.p_big  = x_q[44:43] != 2'b00;
  assign stat_o.r_ge   = r_q >= itp_pkg::REM_3125;
  assign stat_o.o_busy = out_valid_o && out_stall_i;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the inductive track position block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W = 28;
  localparam int unsigned THR_W = itp_pkg::THR_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = '1;
  localparam longint SAMPLE_TOP = (longint'(1) << SAMPLE_W) - 1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MID = SAMPLE_FULL >> 1;
  localparam logic [THR_W-1:0] THR_TOP = '1;

  // The action code and the register index that the block does not use.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam longint LEVEL_TOP = 2097151;
  localparam longint LEVEL_BOTTOM = -2097152;
  // Beyond this error the cubic is known to saturate.
  localparam longint CUBIC_REACH = 100000;

  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned PHASE_BEATS = 120;
  localparam int unsigned RANDOM_PHASES = 8;

  // One result beat as the block presents it.
  typedef struct {
    logic signed [itp_pkg::LVL_W-1:0] left_level;
    logic signed [itp_pkg::LVL_W-1:0] right_level;
    logic signed [itp_pkg::ERR_W-1:0] side_error;
    logic signed [itp_pkg::POS_W-1:0] position;
    logic                             lost;
    logic                             crossing;
  } reading_t;

  // Tracks the block's offsets, thresholds and held position, and keeps the
  // readings that accepted measure beats are owed, oldest first.
  class track_scoreboard;
    longint lost_thr = itp_pkg::LOST_RST;
    longint cc_thr = itp_pkg::CC_RST;
    longint cs_thr = itp_pkg::CS_RST;
    logic [SAMPLE_W-1:0] off_left;
    logic [SAMPLE_W-1:0] off_centre;
    logic [SAMPLE_W-1:0] off_right;
    logic signed [itp_pkg::POS_W-1:0] held_pos;
    reading_t readings[$];
    int unsigned faults;

    function new();
      off_left = '0;
      off_centre = '0;
      off_right = '0;
      held_pos = '0;
      faults = 0;
    endfunction

    // Offset-corrected level, divided by 200 toward zero and clipped to 22 bits.
    function longint scale(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] o);
      longint d;
      longint so;
      d = s;
      so = o;
      d = (d - so) / 200;
      if (d > LEVEL_TOP) d = LEVEL_TOP;
      if (d < LEVEL_BOTTOM) d = LEVEL_BOTTOM;
      return d;
    endfunction

    function void note_beat(logic [1:0] act, logic [SAMPLE_W-1:0] l,
                            logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] r);
      longint lv, cv, rv, e, p;
      logic [SAMPLE_W:0] sum_l, sum_c, sum_r;
      reading_t want;
      case (act)
        itp_pkg::ACT_CAL_START: begin
          off_left = l;
          off_centre = c;
          off_right = r;
        end
        itp_pkg::ACT_CAL_ACC: begin
          // Running average, rounded down.
          sum_l = {1'b0, off_left} + l;
          sum_c = {1'b0, off_centre} + c;
          sum_r = {1'b0, off_right} + r;
          off_left = sum_l[SAMPLE_W:1];
          off_centre = sum_c[SAMPLE_W:1];
          off_right = sum_r[SAMPLE_W:1];
        end
        itp_pkg::ACT_MEAS: begin
          lv = scale(l, off_left);
          cv = scale(c, off_centre);
          rv = scale(r, off_right);
          e = rv - lv;
          want.lost = cv < lost_thr;
          want.crossing = cv >= cc_thr && lv > cs_thr && rv > cs_thr;
          if (!want.lost && !want.crossing) begin
            if (e > CUBIC_REACH) begin
              held_pos = itp_pkg::POS_MAX;
            end else if (e < -CUBIC_REACH) begin
              held_pos = itp_pkg::POS_MIN;
            end else begin
              // Scaled by 1e5: 1e-5 e^3 - 1e-4 e^2 + 1.6577 e - 20.604.
              p = (e * e * e - 10 * e * e + 165770 * e - 2060400) / 100000;
              if (p > itp_pkg::POS_MAX) p = itp_pkg::POS_MAX;
              if (p < itp_pkg::POS_MIN) p = itp_pkg::POS_MIN;
              held_pos = p[itp_pkg::POS_W-1:0];
            end
          end
          want.left_level = lv[itp_pkg::LVL_W-1:0];
          want.right_level = rv[itp_pkg::LVL_W-1:0];
          want.side_error = e[itp_pkg::ERR_W-1:0];
          want.position = held_pos;
          readings.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic signed [63:0] want_v, logic signed [63:0] got_v);
      faults++;
      if (faults <= 10) begin
        $display("mismatch in %s: expected %0d, got %0d", what, want_v, got_v);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (readings.size() == 0) begin
        flag("position of a result with nothing pending", 0, got.position);
        return;
      end
      want = readings.pop_front();
      if (got.left_level !== want.left_level)
        flag("left_level", want.left_level, got.left_level);
      if (got.right_level !== want.right_level)
        flag("right_level", want.right_level, got.right_level);
      if (got.side_error !== want.side_error)
        flag("side_error", want.side_error, got.side_error);
      if (got.position !== want.position)
        flag("position", want.position, got.position);
      if (got.lost !== want.lost)
        flag("lost", want.lost, got.lost);
      if (got.crossing !== want.crossing)
        flag("crossing", want.crossing, got.crossing);
    endfunction
  endclass

  // Every input is known from time zero on.
  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [1:0]                       cfg_idx_i = itp_pkg::REG_LOST;
  logic [THR_W-1:0]                 cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [1:0]                       action_i = itp_pkg::ACT_MEAS;
  logic [SAMPLE_W-1:0]              left_sample_i = '0;
  logic [SAMPLE_W-1:0]              centre_sample_i = '0;
  logic [SAMPLE_W-1:0]              right_sample_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic signed [itp_pkg::LVL_W-1:0] left_level_o;
  logic signed [itp_pkg::LVL_W-1:0] right_level_o;
  logic signed [itp_pkg::ERR_W-1:0] side_error_o;
  logic signed [itp_pkg::POS_W-1:0] position_o;
  logic                             lost_o;
  logic                             crossing_o;

  // Chance, in percent, that the sender skips a cycle or the receiver stalls one.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  track_scoreboard sb;

  inductive_track_position #(
    .SAMPLE_BITS(SAMPLE_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .left_sample_i  (left_sample_i),
    .centre_sample_i(centre_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_level_o   (left_level_o),
    .right_level_o  (right_level_o),
    .side_error_o   (side_error_o),
    .position_o     (position_o),
    .lost_o         (lost_o),
    .crossing_o     (crossing_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random; one assignment per edge keeps it race free.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // A result beat moves at an edge where valid is high and stall is low.
  // Reading right at the edge sees the values from before it.
  always @(posedge clk_i) begin
    reading_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.left_level = left_level_o;
      got.right_level = right_level_o;
      got.side_error = side_error_o;
      got.position = position_o;
      got.lost = lost_o;
      got.crossing = crossing_o;
      sb.check_reading(got);
    end
  end

  function automatic longint pick_span(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  // A raw sample that scales to the given level over the given offset, with
  // a random remainder of the division; clipped to the sample range.
  function automatic logic [SAMPLE_W-1:0] sample_at(logic [SAMPLE_W-1:0] off, longint lvl);
    longint s;
    s = off;
    s = s + lvl * 200 + (lvl < 0 ? -pick_span(0, 199) : pick_span(0, 199));
    if (s < 0) s = 0;
    if (s > SAMPLE_TOP) s = SAMPLE_TOP;
    return s[SAMPLE_W-1:0];
  endfunction

  // Offers one input beat, after a random number of idle cycles, and holds it
  // until the block takes it. Valid stays high afterwards so that back-to-back
  // beats need no second assignment in one step.
  task automatic send_beat(input logic [1:0] act, input logic [SAMPLE_W-1:0] l,
                           input logic [SAMPLE_W-1:0] c, input logic [SAMPLE_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    left_sample_i <= l;
    centre_sample_i <= c;
    right_sample_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(act, l, c, r);
  endtask

  // Lets every owed reading arrive, then gives a calibration beat still in
  // flight time to finish, so that the block is idle afterwards.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three thresholds on consecutive edges, after a write to the
  // unused index that the block must ignore.
  task automatic load_thresholds(input logic [THR_W-1:0] lost_v,
                                 input logic [THR_W-1:0] cc_v,
                                 input logic [THR_W-1:0] cs_v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_SPARE;
    cfg_data_i <= THR_W'($urandom);
    @(posedge clk_i);
    cfg_idx_i <= itp_pkg::REG_LOST;
    cfg_data_i <= lost_v;
    @(posedge clk_i);
    cfg_idx_i <= itp_pkg::REG_CC;
    cfg_data_i <= cc_v;
    @(posedge clk_i);
    cfg_idx_i <= itp_pkg::REG_CS;
    cfg_data_i <= cs_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.lost_thr = lost_v;
    sb.cc_thr = cc_v;
    sb.cs_thr = cs_v;
  endtask

  // One random beat. Most beats are measurements shaped around the current
  // offsets and thresholds, so that flag edges and the cubic are reached;
  // the rest recalibrate or are plain noise. Beats with the unused action
  // are not counted.
  task automatic random_beat(output bit counted);
    int unsigned pick;
    longint cl, ll, rl;
    logic [1:0] act;
    pick = $urandom_range(99);
    counted = 1'b1;
    if (pick < 5) begin
      if ($urandom_range(3) == 0) begin
        send_beat(itp_pkg::ACT_CAL_START, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                  SAMPLE_W'($urandom));
      end else begin
        send_beat(itp_pkg::ACT_CAL_START,
                  sample_at(SAMPLE_MID, pick_span(-80000, 80000)),
                  sample_at(SAMPLE_MID, pick_span(-80000, 80000)),
                  sample_at(SAMPLE_MID, pick_span(-80000, 80000)));
      end
    end else if (pick < 12) begin
      send_beat(itp_pkg::ACT_CAL_ACC, sample_at(sb.off_left, pick_span(-20, 20)),
                sample_at(sb.off_centre, pick_span(-20, 20)),
                sample_at(sb.off_right, pick_span(-20, 20)));
    end else if (pick < 17) begin
      act = 2'($urandom_range(3));
      counted = (act != ACT_SPARE);
      send_beat(act, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    end else begin
      case ($urandom_range(3))
        0: cl = sb.lost_thr + pick_span(-2, 2);
        1: cl = sb.cc_thr + pick_span(-2, 2);
        2: cl = pick_span(0, 3000);
        default: cl = pick_span(-1000, 1342177);
      endcase
      case ($urandom_range(2))
        0: ll = sb.cs_thr + pick_span(-2, 2);
        1: ll = pick_span(-3000, 3000);
        default: ll = pick_span(-600000, 600000);
      endcase
      // The right level sets the error: small, within the cubic's unsaturated
      // span, just around the saturation edge, or at the side threshold.
      case ($urandom_range(3))
        0: rl = sb.cs_thr + pick_span(-2, 2);
        1: rl = ll + pick_span(-300, 300);
        2: rl = ll + pick_span(-65000, 65000);
        default: rl = ll + pick_span(-110000, 110000);
      endcase
      send_beat(itp_pkg::ACT_MEAS, sample_at(sb.off_left, ll),
                sample_at(sb.off_centre, cl), sample_at(sb.off_right, rl));
    end
  endtask

  initial begin
    int unsigned beats;
    bit counted;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset thresholds and zero offsets.
    // All zero: the centre is below the lost threshold, position holds zero.
    send_beat(itp_pkg::ACT_MEAS, '0, '0, '0);
    // Zero error with a strong centre gives the polynomial's constant term.
    send_beat(itp_pkg::ACT_MEAS, '0, SAMPLE_FULL, '0);
    // Full scale everywhere is a crossing, so the position is held.
    send_beat(itp_pkg::ACT_MEAS, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL);
    // Largest errors of both signs saturate.
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd100000, SAMPLE_FULL);
    send_beat(itp_pkg::ACT_MEAS, SAMPLE_FULL, 28'd100000, '0);
    // Errors of exactly the saturation edge and one beyond it.
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd100000, 28'd20000000);
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd100000, 28'd20000200);
    send_beat(itp_pkg::ACT_MEAS, 28'd20000000, 28'd100000, '0);
    // Around where the cubic itself overflows 32 bits.
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd100000, 28'd11800000);
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd100000, 28'd12000000);
    send_beat(itp_pkg::ACT_MEAS, 28'd11800000, 28'd100000, '0);
    // Centre level right at the lost threshold, then one below it.
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd4000, 28'd4000);
    send_beat(itp_pkg::ACT_MEAS, '0, 28'd3999, '0);
    // Crossing edges: all just past, one side at the threshold, centre short.
    send_beat(itp_pkg::ACT_MEAS, 28'd20200, 28'd50000, 28'd20200);
    send_beat(itp_pkg::ACT_MEAS, 28'd20000, 28'd50000, 28'd20200);
    send_beat(itp_pkg::ACT_MEAS, 28'd20200, 28'd49999, 28'd20200);
    // Samples below the offset truncate toward zero.
    send_beat(itp_pkg::ACT_CAL_START, 28'd1000, 28'd1000, 28'd1000);
    send_beat(itp_pkg::ACT_MEAS, 28'd601, 28'd5000, 28'd1199);
    // Averaging toward full scale, an odd sum, and full-scale offsets.
    send_beat(itp_pkg::ACT_CAL_ACC, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL);
    send_beat(itp_pkg::ACT_MEAS, 28'd601, 28'd5000, 28'd1199);
    send_beat(itp_pkg::ACT_CAL_START, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL);
    send_beat(itp_pkg::ACT_CAL_ACC, SAMPLE_FULL, SAMPLE_FULL, SAMPLE_FULL);
    send_beat(itp_pkg::ACT_MEAS, '0, '0, '0);
    send_beat(itp_pkg::ACT_CAL_ACC, '0, 28'd1, '0);
    // The unused action changes nothing.
    send_beat(ACT_SPARE, SAMPLE_FULL, '0, SAMPLE_FULL);
    send_beat(itp_pkg::ACT_MEAS, SAMPLE_MID, SAMPLE_MID, SAMPLE_MID);

    // Random phases, each with its own thresholds and idling pattern.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        0: load_thresholds('0, '0, '0);
        1: load_thresholds(THR_TOP, THR_TOP, THR_TOP);
        2: load_thresholds(itp_pkg::LOST_RST, itp_pkg::CC_RST, itp_pkg::CS_RST);
        3: load_thresholds('0, THR_TOP, '0);
        4: load_thresholds(THR_W'(pick_span(0, 6)), '0, '0);
        default: load_thresholds(THR_W'(pick_span(0, 400)), THR_W'(pick_span(0, 3000)),
                                 THR_W'(pick_span(0, 1500)));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          send_idle_pct = 22;
          stall_pct = 22;
        end
      endcase
      beats = 0;
      while (beats < PHASE_BEATS) begin
        random_beat(counted);
        if (counted) beats++;
      end
    end

    settle();
    if (sb.faults == 0 && sb.readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
